FILE: rtl/core/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants of the escape-time counter: register indexes,
// sequencer states, multiplier operand codes and the control word.
// ----------------------------------------------------------------------------
package mbe_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_REAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IMAG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_REAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IMAG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER      = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_CR,
        S_MUL_CI,
        S_PT_CI,
        S_SQ_RE,
        S_SQ_IM,
        S_CROSS,
        S_UPDATE
    } t_state;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_COL_STEP,
        MUL_ROW_STEP,
        MUL_ZR_ZR,
        MUL_ZI_ZI,
        MUL_ZR_ZI
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_cr;
        logic     ld_ci;
        logic     init_z;
        logic     ld_zr2;
        logic     ld_zi2;
        logic     step_z;
        logic     ld_out;
    } t_ctrl;

endpackage

FILE: rtl/core/mbe_pix_if.sv
// ----------------------------------------------------------------------------
// mbe_pix_if
// Pixel coordinate channel: valid/ready handshake with column and row.
// ----------------------------------------------------------------------------
interface mbe_pix_if #(
    parameter int INDEX_WIDTH = 12
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] column;
    logic [INDEX_WIDTH-1:0] row;

    modport source (output valid, output column, output row, input ready);
    modport sink   (input valid, input column, input row, output ready);
endinterface

FILE: rtl/core/mbe_res_if.sv
// ----------------------------------------------------------------------------
// mbe_res_if
// Result channel: valid/ready handshake with iteration count and escape flag.
// ----------------------------------------------------------------------------
interface mbe_res_if #(
    parameter int COUNT_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] iteration_count;
    logic                   escaped;

    modport source (output valid, output iteration_count, output escaped, input ready);
    modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

FILE: rtl/core/mbe_cfg.sv
// ----------------------------------------------------------------------------
// mbe_cfg
// Configuration register file: origin, step and iteration cap.
// ----------------------------------------------------------------------------
module mbe_cfg #(
    parameter int COORD_WIDTH = 32,
    parameter int COUNT_WIDTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]               i_cfg_data,
    output logic signed [COORD_WIDTH-1:0]       o_origin_re,
    output logic signed [COORD_WIDTH-1:0]       o_origin_im,
    output logic signed [COORD_WIDTH-1:0]       o_step_re,
    output logic signed [COORD_WIDTH-1:0]       o_step_im,
    output logic [COUNT_WIDTH-1:0]              o_max_iter
);
    localparam int FB = COORD_WIDTH - 4;

    // -2.0, -1.5 and 2^-8 in Q4.FB
    localparam logic signed [COORD_WIDTH-1:0] RST_ORIGIN_RE = {4'b1110, {FB{1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] RST_ORIGIN_IM = {5'b11101, {(FB-1){1'b0}}};
    localparam logic signed [COORD_WIDTH-1:0] RST_STEP =
        {{(COORD_WIDTH-FB+7){1'b0}}, 1'b1, {(FB-8){1'b0}}};
    localparam logic [COUNT_WIDTH-1:0] RST_MAX_ITER = COUNT_WIDTH'(256);

    logic signed [COORD_WIDTH-1:0] r_origin_re;
    logic signed [COORD_WIDTH-1:0] r_origin_im;
    logic signed [COORD_WIDTH-1:0] r_step_re;
    logic signed [COORD_WIDTH-1:0] r_step_im;
    logic [COUNT_WIDTH-1:0]        r_max_iter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_re <= RST_ORIGIN_RE;
            r_origin_im <= RST_ORIGIN_IM;
            r_step_re   <= RST_STEP;
            r_step_im   <= RST_STEP;
            r_max_iter  <= RST_MAX_ITER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mbe_pkg::CFG_ORIGIN_REAL: r_origin_re <= i_cfg_data[COORD_WIDTH-1:0];
                mbe_pkg::CFG_ORIGIN_IMAG: r_origin_im <= i_cfg_data[COORD_WIDTH-1:0];
                mbe_pkg::CFG_STEP_REAL:   r_step_re   <= i_cfg_data[COORD_WIDTH-1:0];
                mbe_pkg::CFG_STEP_IMAG:   r_step_im   <= i_cfg_data[COORD_WIDTH-1:0];
                mbe_pkg::CFG_MAX_ITER:    r_max_iter  <= i_cfg_data[COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_origin_re = r_origin_re;
    assign o_origin_im = r_origin_im;
    assign o_step_re   = r_step_re;
    assign o_step_im   = r_step_im;
    assign o_max_iter  = r_max_iter;
endmodule

FILE: rtl/core/mbe_mult.sv
// ----------------------------------------------------------------------------
// mbe_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mbe_mult #(
    parameter int OP_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic signed [OP_WIDTH-1:0]     i_a,
    input  logic signed [OP_WIDTH-1:0]     i_b,
    output logic signed [2*OP_WIDTH-1:0]   o_prod
);
    logic signed [2*OP_WIDTH-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

FILE: rtl/core/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer: point setup, then square, square, cross product and update
// per iteration on the shared multiplier.
// ----------------------------------------------------------------------------
module mbe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_fire,
    input  logic            i_stop,
    input  logic            i_out_free,
    output logic            o_in_ready,
    output mbe_pkg::t_ctrl  o_ctrl
);
    mbe_pkg::t_state r_state;
    mbe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbe_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mbe_pkg::S_IDLE: begin
                if (i_in_fire) n_state = mbe_pkg::S_MUL_CR;
            end
            mbe_pkg::S_MUL_CR: n_state = mbe_pkg::S_MUL_CI;
            mbe_pkg::S_MUL_CI: n_state = mbe_pkg::S_PT_CI;
            mbe_pkg::S_PT_CI:  n_state = mbe_pkg::S_SQ_RE;
            mbe_pkg::S_SQ_RE:  n_state = mbe_pkg::S_SQ_IM;
            mbe_pkg::S_SQ_IM:  n_state = mbe_pkg::S_CROSS;
            mbe_pkg::S_CROSS:  n_state = mbe_pkg::S_UPDATE;
            mbe_pkg::S_UPDATE: begin
                // once the point stops, hold here until the result register can take the word
                if (!i_stop) begin
                    n_state = mbe_pkg::S_SQ_RE;
                end else if (i_out_free) begin
                    n_state = mbe_pkg::S_IDLE;
                end
            end
            default: n_state = mbe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_ctrl.mul_sel = mbe_pkg::MUL_ZR_ZR;
        o_in_ready = 1'b0;
        unique case (r_state)
            mbe_pkg::S_IDLE: o_in_ready = 1'b1;
            mbe_pkg::S_MUL_CR: o_ctrl.mul_sel = mbe_pkg::MUL_COL_STEP;
            mbe_pkg::S_MUL_CI: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_ROW_STEP;
                o_ctrl.ld_cr   = 1'b1;
            end
            mbe_pkg::S_PT_CI: begin
                o_ctrl.ld_ci  = 1'b1;
                o_ctrl.init_z = 1'b1;
            end
            mbe_pkg::S_SQ_RE: o_ctrl.mul_sel = mbe_pkg::MUL_ZR_ZR;
            mbe_pkg::S_SQ_IM: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_ZI_ZI;
                o_ctrl.ld_zr2  = 1'b1;
            end
            mbe_pkg::S_CROSS: begin
                o_ctrl.mul_sel = mbe_pkg::MUL_ZR_ZI;
                o_ctrl.ld_zi2  = 1'b1;
            end
            mbe_pkg::S_UPDATE: begin
                o_ctrl.step_z = !i_stop;
                o_ctrl.ld_out = i_stop && i_out_free;
            end
            default: begin
            end
        endcase
    end
endmodule

FILE: rtl/core/mandelbrot_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// Escape-time counter for one pixel, Q4.28 fixed point with saturation.
// ----------------------------------------------------------------------------
// usage
//   i_pix carries one pixel word (column, row); o_res returns one word
//   (iteration_count, escaped) per pixel, in order.
//   i_cfg_we / i_cfg_idx / i_cfg_data write origin, step and the iteration
//   cap; write them only while no pixel is in flight.
//   the point c is formed on the shared multiplier first, then every
//   iteration runs on it in order: z.re squared, z.im squared, cross
//   product, compare and update.
//   i_pix.ready is high only while no pixel is being worked on, so a new
//   pixel is taken only once the last one has handed over its result.
//   the result sits in an output register; the next pixel is accepted while
//   it waits, and that pixel stalls in its last step while the receiver
//   holds o_res.ready low.
//   synchronous reset drops the result valid, returns the sequencer to idle and
//   loads the default view (-2.0, -1.5, step 2^-8, cap 256).
// ----------------------------------------------------------------------------
module mandelbrot_escape_count #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 12,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mbe_pix_if.sink                               i_pix,
    mbe_res_if.source                             o_res,
    input  logic                                  i_cfg_we,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((COORD_WIDTH > COUNT_WIDTH) ? COORD_WIDTH : COUNT_WIDTH)-1:0] i_cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int IW = INDEX_WIDTH;
    localparam int NW = COUNT_WIDTH;
    localparam int DW = (CW > NW) ? CW : NW;
    localparam int FB = CW - 4;
    localparam int OW = (CW > IW) ? CW : IW + 1;
    localparam int PW = 2 * OW;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [PW:0]   SAT_HI    = (PW+1)'(COORD_MAX);
    localparam logic signed [PW:0]   SAT_LO    = (PW+1)'(COORD_MIN);
    localparam logic signed [CW:0]   FOUR      = {3'b001, {(CW-2){1'b0}}};

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW:0] v);
        logic signed [CW-1:0] res;
        if (v > SAT_HI) begin
            res = COORD_MAX;
        end else if (v < SAT_LO) begin
            res = COORD_MIN;
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic signed [CW-1:0] origin_re;
    logic signed [CW-1:0] origin_im;
    logic signed [CW-1:0] step_re;
    logic signed [CW-1:0] step_im;
    logic [NW-1:0]        max_iter;

    mbe_pkg::t_ctrl ctrl;
    logic           in_ready;
    logic           in_fire;
    logic           stop;
    logic           out_free;

    logic [IW-1:0]        r_col;
    logic [IW-1:0]        r_row;
    logic signed [CW-1:0] r_cr;
    logic signed [CW-1:0] r_ci;
    logic signed [CW-1:0] r_zr;
    logic signed [CW-1:0] r_zi;
    logic signed [CW-1:0] r_zr2;
    logic signed [CW-1:0] r_zi2;
    logic [NW-1:0]        r_count;

    logic          r_out_valid;
    logic [NW-1:0] r_out_count;
    logic          r_out_esc;

    logic signed [OW-1:0] mul_a;
    logic signed [OW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    logic signed [CW-1:0] cr_next;
    logic signed [CW-1:0] ci_next;
    logic signed [CW-1:0] sq_next;
    logic signed [CW-1:0] cross_term;
    logic signed [CW-1:0] zr_new;
    logic signed [CW-1:0] zi_new;
    logic signed [CW:0]   mag;
    logic                 at_cap;

    mbe_cfg #(
        .COORD_WIDTH (CW),
        .COUNT_WIDTH (NW),
        .DATA_WIDTH  (DW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_origin_re (origin_re),
        .o_origin_im (origin_im),
        .o_step_re   (step_re),
        .o_step_im   (step_im),
        .o_max_iter  (max_iter)
    );

    mbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_stop     (stop),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    always_comb begin
        case (ctrl.mul_sel)
            mbe_pkg::MUL_COL_STEP: begin
                mul_a = $signed(OW'({1'b0, r_col}));
                mul_b = OW'(step_re);
            end
            mbe_pkg::MUL_ROW_STEP: begin
                mul_a = $signed(OW'({1'b0, r_row}));
                mul_b = OW'(step_im);
            end
            mbe_pkg::MUL_ZI_ZI: begin
                mul_a = OW'(r_zi);
                mul_b = OW'(r_zi);
            end
            mbe_pkg::MUL_ZR_ZI: begin
                mul_a = OW'(r_zr);
                mul_b = OW'(r_zi);
            end
            default: begin
                mul_a = OW'(r_zr);
                mul_b = OW'(r_zr);
            end
        endcase
    end

    mbe_mult #(
        .OP_WIDTH (OW)
    ) u_mult (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign cr_next = sat_coord((PW+1)'(origin_re) + (PW+1)'(prod));
    assign ci_next = sat_coord((PW+1)'(origin_im) + (PW+1)'(prod));
    assign sq_next = sat_coord((PW+1)'(prod >>> FB));
    // cross term is 2*zr*zi, hence one bit less of shift
    assign cross_term = sat_coord((PW+1)'(prod >>> (FB - 1)));
    assign zi_new  = sat_coord((PW+1)'(cross_term) + (PW+1)'(r_ci));
    assign zr_new  = sat_coord((PW+1)'(r_zr2) - (PW+1)'(r_zi2) + (PW+1)'(r_cr));
    assign mag     = (CW+1)'(r_zr2) + (CW+1)'(r_zi2);
    assign at_cap  = (r_count >= max_iter);
    assign stop    = at_cap || (mag >= FOUR);

    assign in_fire  = i_pix.valid && in_ready;
    assign out_free = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_col <= i_pix.column;
            r_row <= i_pix.row;
        end
        if (ctrl.ld_cr) r_cr <= cr_next;
        if (ctrl.ld_ci) r_ci <= ci_next;
        if (ctrl.ld_zr2) r_zr2 <= sq_next;
        if (ctrl.ld_zi2) r_zi2 <= sq_next;
        if (ctrl.init_z) begin
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else if (ctrl.step_z) begin
            r_zr    <= zr_new;
            r_zi    <= zi_new;
            r_count <= r_count + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.ld_out) begin
            r_out_count <= r_count;
            r_out_esc   <= !at_cap;
        end
    end

    assign i_pix.ready           = in_ready;
    assign o_res.valid           = r_out_valid;
    assign o_res.iteration_count = r_out_count;
    assign o_res.escaped         = r_out_esc;
endmodule

FILE: rtl/core/mbe_checker.sv
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks of the escape-time counter, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [COUNT_WIDTH-1:0] i_out_count,
    input logic                   i_out_escaped
);
    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_count) && $stable(i_out_escaped)))
        else $error("result word changed while stalled");

    // busy once a pixel is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("pixel accepted while another is in work");

    // a result never appears the cycle after a pixel is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result too early after accept");

    // reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");
endmodule

bind mandelbrot_escape_count mbe_checker #(
    .COUNT_WIDTH (COUNT_WIDTH)
) u_mbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_count   (o_res.iteration_count),
    .i_out_escaped (o_res.escaped)
);
